[hw/rtl/tscs_pkg.sv]
// Shared constants, codes and helpers of the two-shunt phase current sense block
`timescale 1ns / 1ps

package tscs_pkg;

  // sample and arithmetic widths
  localparam int SAMPLE_BITS = 12;
  localparam int OFF_W       = 16;
  localparam int OFF_SHIFT   = OFF_W - SAMPLE_BITS;
  localparam int CUR_SHIFT   = 24 - SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + 12;
  localparam int CNT_W       = 12;
  localparam int GAIN_W      = 24;
  localparam int CUR_W       = 24;
  localparam int CMD_W       = 2;

  // serial multiplier: offset-corrected sample times gain
  localparam int MPL_W       = OFF_W + 2;
  localparam int PROD_W      = GAIN_W + MPL_W + 1;
  localparam int SHR_W       = PROD_W - CUR_SHIFT;
  localparam int MUL_CNT_W   = $clog2(MPL_W + 1);

  // serial divider for the offset average
  localparam int DIVD_W      = SUM_W + OFF_SHIFT + 1;
  localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);

  // calibration start-up discard
  localparam int DISC_W      = 2;
  localparam logic [DISC_W-1:0] CAL_DISCARD = 2'd3;

  // item commands
  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CALIB   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN   = 2'd2;

  // configuration port
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CALIB = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SKIP  = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd4226;
  localparam logic [CNT_W-1:0]  CALIB_RST = 12'd2000;

  // clamp a shifted product to the signed current range
  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [SHR_W-1:0] v);
    logic ovf;
    ovf = (v[SHR_W-1:CUR_W-1] != {(SHR_W-CUR_W+1){v[SHR_W-1]}});
    return ovf ? {v[SHR_W-1], {(CUR_W-1){~v[SHR_W-1]}}} : v[CUR_W-1:0];
  endfunction

endpackage

[hw/rtl/tscs_if.sv]
// Item channels: sample pairs in, phase currents out
`timescale 1ns / 1ps

interface tscs_in_if;
  logic                          valid;
  logic                          ready;
  logic [tscs_pkg::CMD_W-1:0]    cmd;
  logic [tscs_pkg::SAMPLE_BITS-1:0] sample_a;
  logic [tscs_pkg::SAMPLE_BITS-1:0] sample_c;

  modport source (output valid, cmd, sample_a, sample_c, input ready);
  modport sink (input valid, cmd, sample_a, sample_c, output ready);
endinterface

interface tscs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tscs_pkg::CUR_W-1:0]   current_a;
  logic signed [tscs_pkg::CUR_W-1:0]   current_b;
  logic signed [tscs_pkg::CUR_W-1:0]   current_c;
  logic                                cal_done;
  logic                                a_flipped;
  logic                                c_flipped;

  modport source (output valid, current_a, current_b, current_c, cal_done, a_flipped,
                  c_flipped, input ready);
  modport sink (input valid, current_a, current_b, current_c, cal_done, a_flipped,
                c_flipped, output ready);
endinterface

[hw/rtl/tscs_mul.sv]
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module tscs_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tscs_pkg::GAIN_W-1:0]   mcand_i,
  input  logic signed [tscs_pkg::MPL_W-1:0]    mplier_i,
  output logic                                 busy_o,
  output logic signed [tscs_pkg::PROD_W-1:0]   prod_o
);

  logic                              busy_q;
  logic [tscs_pkg::MUL_CNT_W-1:0]    cnt_q;
  logic [tscs_pkg::GAIN_W-1:0]       mcand_q;
  logic [tscs_pkg::GAIN_W:0]         hi_q;
  logic [tscs_pkg::MPL_W-1:0]        lo_q;
  logic [tscs_pkg::GAIN_W:0]         addend;
  logic [tscs_pkg::GAIN_W+1:0]       sum;
  logic                              last;

  // add or, for the sign bit, subtract the multiplicand
  assign last   = (cnt_q == tscs_pkg::MUL_CNT_W'(tscs_pkg::MPL_W - 1));
  assign addend = lo_q[0] ? {mcand_q[tscs_pkg::GAIN_W-1], mcand_q} : '0;
  assign sum    = last ? ({hi_q[tscs_pkg::GAIN_W], hi_q} - {addend[tscs_pkg::GAIN_W], addend})
                       : ({hi_q[tscs_pkg::GAIN_W], hi_q} + {addend[tscs_pkg::GAIN_W], addend});

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // partial product shifts right one bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[tscs_pkg::GAIN_W+1:1];
      lo_q <= {sum[0], lo_q[tscs_pkg::MPL_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

endmodule

[hw/rtl/tscs_div.sv]
// Restoring divider for the offset average, one quotient bit per cycle
`timescale 1ns / 1ps

module tscs_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tscs_pkg::DIVD_W-1:0]        dividend_i,
  input  logic [tscs_pkg::CNT_W-1:0]         divisor_i,
  output logic                               busy_o,
  output logic [tscs_pkg::OFF_W-1:0]         quotient_o
);

  logic                              busy_q;
  logic [tscs_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [tscs_pkg::DIVD_W-1:0]       quo_q;
  logic [tscs_pkg::CNT_W-1:0]        rem_q;
  logic [tscs_pkg::CNT_W-1:0]        dvs_q;
  logic [tscs_pkg::CNT_W:0]          shifted;
  logic [tscs_pkg::CNT_W:0]          trial;
  logic                              fits;
  logic                              last;

  // trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_q, quo_q[tscs_pkg::DIVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});
  assign last    = (cnt_q == tscs_pkg::DIV_CNT_W'(tscs_pkg::DIVD_W - 1));

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[tscs_pkg::DIVD_W-2:0], fits};
      rem_q <= fits ? trial[tscs_pkg::CNT_W-1:0] : shifted[tscs_pkg::CNT_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[tscs_pkg::OFF_W-1:0];

endmodule

[hw/rtl/two_shunt_phase_current_sense.sv]
// Top level: two-shunt phase current sense with offset calibration and polarity align
// The result is registered once the 18-step bit-serial multipliers are done and, for the calibrate
//   item that closes a run, also the bit-serial 29-step offset dividers.
// Only one item is in flight at a time: the next item is taken once the result is registered,
//   and a result still waiting at the output holds back that load.
// Reset: asynchronous active low; clears offsets, run state and phase signs and loads
//   the register defaults; no clearing pass.
`timescale 1ns / 1ps

module two_shunt_phase_current_sense (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tscs_in_if.sink                          in_i,
  tscs_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tscs_pkg::APB_AW-1:0]      paddr,
  input  logic [tscs_pkg::APB_DW-1:0]      pwdata,
  output logic [tscs_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // configuration registers
  logic signed [tscs_pkg::GAIN_W-1:0]  gain_q;
  logic [tscs_pkg::CNT_W-1:0]          calib_q;
  logic                                skip_q;

  // calibration and polarity state
  logic [tscs_pkg::OFF_W-1:0]          offset_a_q, offset_c_q;
  logic [tscs_pkg::SUM_W-1:0]          sum_a_q, sum_c_q;
  logic [tscs_pkg::CNT_W-1:0]          cal_cnt_q;
  logic [tscs_pkg::DISC_W-1:0]         disc_q;
  logic                                sign_a_q, sign_c_q;

  // item control
  logic                                state_q;
  logic                                align_q;
  logic                                cal_pend_q;

  // output register
  logic                                out_valid_q;
  logic signed [tscs_pkg::CUR_W-1:0]   cur_a_q, cur_b_q, cur_c_q;
  logic                                cal_done_q, a_flip_q, c_flip_q;

  logic                                in_acc;
  logic                                is_cal, in_disc, cal_fin;
  logic [tscs_pkg::SUM_W-1:0]          sum_a_d, sum_c_d;
  logic [tscs_pkg::CNT_W-1:0]          cal_cnt_d;
  logic [tscs_pkg::CNT_W-1:0]          n_eff;
  logic [tscs_pkg::DIVD_W-1:0]         dvd_a, dvd_c;
  logic [tscs_pkg::OFF_W-1:0]          raw_a, raw_c;
  logic signed [tscs_pkg::MPL_W-1:0]   diff_a, diff_c, mpl_a, mpl_c;
  logic signed [tscs_pkg::PROD_W-1:0]  prod_a, prod_c;
  logic [tscs_pkg::OFF_W-1:0]          quo_a, quo_c;
  logic                                mul_a_busy, mul_c_busy, div_a_busy, div_c_busy;
  logic                                all_done, load;
  logic signed [tscs_pkg::CUR_W-1:0]   ia, ic, ib;
  logic signed [tscs_pkg::CUR_W:0]     ac_sum;
  logic signed [tscs_pkg::SHR_W-1:0]   ac_ext;
  logic                                flip_a, flip_c;
  logic                                apb_wr;
  logic [tscs_pkg::REG_IDX_W-1:0]      reg_idx;

  // handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // calibration run bookkeeping for the incoming item
  assign is_cal    = (in_i.cmd == tscs_pkg::CMD_CALIB);
  assign in_disc   = (disc_q < tscs_pkg::CAL_DISCARD);
  assign n_eff     = (calib_q == '0) ? tscs_pkg::CNT_W'(1) : calib_q;
  assign sum_a_d   = sum_a_q + tscs_pkg::SUM_W'(in_i.sample_a);
  assign sum_c_d   = sum_c_q + tscs_pkg::SUM_W'(in_i.sample_c);
  assign cal_cnt_d = cal_cnt_q + 1'b1;
  assign cal_fin   = is_cal && !in_disc && (cal_cnt_d >= n_eff);
  assign dvd_a     = (tscs_pkg::DIVD_W'(sum_a_d) << tscs_pkg::OFF_SHIFT)
                     + tscs_pkg::DIVD_W'(n_eff >> 1);
  assign dvd_c     = (tscs_pkg::DIVD_W'(sum_c_d) << tscs_pkg::OFF_SHIFT)
                     + tscs_pkg::DIVD_W'(n_eff >> 1);

  // offset-corrected sample with the phase sign folded in
  assign raw_a  = tscs_pkg::OFF_W'(in_i.sample_a) << tscs_pkg::OFF_SHIFT;
  assign raw_c  = tscs_pkg::OFF_W'(in_i.sample_c) << tscs_pkg::OFF_SHIFT;
  assign diff_a = $signed({2'b00, raw_a}) - $signed({2'b00, offset_a_q});
  assign diff_c = $signed({2'b00, raw_c}) - $signed({2'b00, offset_c_q});
  assign mpl_a  = sign_a_q ? -diff_a : diff_a;
  assign mpl_c  = sign_c_q ? -diff_c : diff_c;

  tscs_mul u_mul_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .mcand_i  (gain_q),
    .mplier_i (mpl_a),
    .busy_o   (mul_a_busy),
    .prod_o   (prod_a)
  );

  tscs_mul u_mul_c (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .mcand_i  (gain_q),
    .mplier_i (mpl_c),
    .busy_o   (mul_c_busy),
    .prod_o   (prod_c)
  );

  tscs_div u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && cal_fin),
    .dividend_i (dvd_a),
    .divisor_i  (n_eff),
    .busy_o     (div_a_busy),
    .quotient_o (quo_a)
  );

  tscs_div u_div_c (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && cal_fin),
    .dividend_i (dvd_c),
    .divisor_i  (n_eff),
    .busy_o     (div_c_busy),
    .quotient_o (quo_c)
  );

  // currents from the finished products
  assign ia     = tscs_pkg::sat_cur(prod_a[tscs_pkg::PROD_W-1:tscs_pkg::CUR_SHIFT]);
  assign ic     = tscs_pkg::sat_cur(prod_c[tscs_pkg::PROD_W-1:tscs_pkg::CUR_SHIFT]);
  assign ac_sum = {ia[tscs_pkg::CUR_W-1], ia} + {ic[tscs_pkg::CUR_W-1], ic};
  assign ac_ext = tscs_pkg::SHR_W'(ac_sum);
  assign ib     = tscs_pkg::sat_cur(-ac_ext);
  assign flip_a = align_q && prod_a[tscs_pkg::PROD_W-1];
  assign flip_c = align_q && prod_c[tscs_pkg::PROD_W-1];

  assign all_done = !mul_a_busy && !mul_c_busy && !div_a_busy && !div_c_busy;
  assign load     = (state_q == ST_RUN) && all_done && (!out_valid_q || out_o.ready);

  // item sequencing, run state, offsets and signs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      align_q    <= 1'b0;
      cal_pend_q <= 1'b0;
      offset_a_q <= '0;
      offset_c_q <= '0;
      sum_a_q    <= '0;
      sum_c_q    <= '0;
      cal_cnt_q  <= '0;
      disc_q     <= '0;
      sign_a_q   <= 1'b0;
      sign_c_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q    <= ST_RUN;
            align_q    <= (in_i.cmd == tscs_pkg::CMD_ALIGN) && !skip_q;
            cal_pend_q <= cal_fin;
            if (!is_cal || cal_fin) begin
              sum_a_q   <= '0;
              sum_c_q   <= '0;
              cal_cnt_q <= '0;
              disc_q    <= '0;
            end else if (in_disc) begin
              disc_q <= disc_q + 1'b1;
            end else begin
              sum_a_q   <= sum_a_d;
              sum_c_q   <= sum_c_d;
              cal_cnt_q <= cal_cnt_d;
            end
          end
        end
        ST_RUN: begin
          if (load) begin
            state_q <= ST_IDLE;
            if (cal_pend_q) begin
              offset_a_q <= quo_a;
              offset_c_q <= quo_c;
            end
            if (flip_a) begin
              sign_a_q <= ~sign_a_q;
            end
            if (flip_c) begin
              sign_c_q <= ~sign_c_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_a_q    <= ia;
      cur_b_q    <= ib;
      cur_c_q    <= ic;
      cal_done_q <= cal_pend_q;
      a_flip_q   <= flip_a;
      c_flip_q   <= flip_c;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.current_a = cur_a_q;
  assign out_o.current_b = cur_b_q;
  assign out_o.current_c = cur_c_q;
  assign out_o.cal_done  = cal_done_q;
  assign out_o.a_flipped = a_flip_q;
  assign out_o.c_flipped = c_flip_q;

  // configuration port
  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[tscs_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= tscs_pkg::GAIN_RST;
      calib_q <= tscs_pkg::CALIB_RST;
      skip_q  <= 1'b0;
    end else if (apb_wr) begin
      unique case (reg_idx)
        tscs_pkg::REG_GAIN:  gain_q  <= pwdata[tscs_pkg::GAIN_W-1:0];
        tscs_pkg::REG_CALIB: calib_q <= pwdata[tscs_pkg::CNT_W-1:0];
        tscs_pkg::REG_SKIP:  skip_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      tscs_pkg::REG_GAIN:  prdata = tscs_pkg::APB_DW'(unsigned'(gain_q));
      tscs_pkg::REG_CALIB: prdata = tscs_pkg::APB_DW'(calib_q);
      tscs_pkg::REG_SKIP:  prdata = tscs_pkg::APB_DW'(skip_q);
      default:             prdata = '0;
    endcase
  end

endmodule

[hw/rtl/tscs_checker.sv]
// Port-level checker for the phase current sense top level, with its bind
`timescale 1ns / 1ps

module tscs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tscs_pkg::CUR_W-1:0]    cur_a_i,
  input logic [tscs_pkg::CUR_W-1:0]    cur_c_i,
  input logic                          cal_done_i,
  input logic                          a_flip_i,
  input logic                          c_flip_i
);

  // a result item stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped before it was taken");

  // one item at a time: input closes right after an accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // calibration close and polarity flips come from different commands
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(cal_done_i && (a_flip_i || c_flip_i)))
    else $error("cal_done together with a polarity flip");

  // a phase only flips when its reported current is negative
  a_flip_a_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && a_flip_i |-> cur_a_i[tscs_pkg::CUR_W-1])
    else $error("phase A flipped with non-negative current");

  a_flip_c_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && c_flip_i |-> cur_c_i[tscs_pkg::CUR_W-1])
    else $error("phase C flipped with non-negative current");

endmodule

bind two_shunt_phase_current_sense tscs_checker u_tscs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cur_a_i     (out_o.current_a),
  .cur_c_i     (out_o.current_c),
  .cal_done_i  (out_o.cal_done),
  .a_flip_i    (out_o.a_flipped),
  .c_flip_i    (out_o.c_flipped)
);
